>>> rtl/cmdec_pkg.sv
// Shared constants and types for the column median decimator.
package cmdec_pkg;

  localparam int WINDOW   = 32;
  localparam int HALF     = WINDOW / 2;
  localparam int LAG      = WINDOW - 1 - HALF;
  localparam int MAX_ROWS = 4096;
  localparam int PIX_W    = 16;
  localparam int ROW_W    = 12;
  localparam int CNT_W    = ROW_W + 1;
  localparam int AGE_W    = $clog2(WINDOW);
  localparam int STEP_W   = 7;
  localparam int PHASE_W  = 6;

  localparam logic [PIX_W-1:0]  FILL        = '1;
  localparam logic [AGE_W-1:0]  OLDEST      = AGE_W'(WINDOW - 1);
  localparam logic [STEP_W-1:0] STEP_RESET  = STEP_W'(10);
  localparam logic [STEP_W-1:0] STEP_MAX    = STEP_W'(64);

  typedef struct packed {
    logic [PIX_W-1:0] depth_in;
    logic             last_in_column;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] depth_out;
    logic [ROW_W-1:0] row_out;
    logic             last_out;
  } out_item_t;

  // Broadcast from the controller to every cell of the sorted chain.
  typedef struct packed {
    logic             push;
    logic             clear;
    logic [PIX_W-1:0] new_val;
  } cell_ctl_t;

endpackage

>>> rtl/cmdec_cell.sv
// One cell of the sorted window chain: holds a pixel and its age.
module cmdec_cell
  import cmdec_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  logic [AGE_W-1:0] init_age,
  input  logic [PIX_W-1:0] left_val,
  input  logic [AGE_W-1:0] left_age,
  input  logic             left_gt,
  input  logic [PIX_W-1:0] right_val,
  input  logic [AGE_W-1:0] right_age,
  input  logic             right_gt,
  input  logic             below_in,
  output logic [PIX_W-1:0] val,
  output logic [AGE_W-1:0] age,
  output logic             gt,
  output logic             below_out
);

  logic [PIX_W-1:0] val_r, val_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;
  logic             self_before_del;
  logic             prev_before_del;
  logic             keep_low;
  logic             prev_low;

  assign gt        = val_r > ctl.new_val;
  assign below_out = below_in | (age_r == OLDEST);
  assign val       = val_r;
  assign age       = age_r;

  // The oldest entry leaves the chain and the new pixel goes in after every
  // entry that is not greater; each cell picks from its neighbors to match.
  always_comb begin
    self_before_del = !below_out;
    prev_before_del = !below_in;
    keep_low = self_before_del ? !gt : !right_gt;
    prev_low = prev_before_del ? !left_gt : !gt;
    val_nxt  = val_r;
    age_nxt  = age_r;
    if (keep_low) begin
      if (self_before_del) begin
        age_nxt = age_r + 1'b1;
      end else begin
        val_nxt = right_val;
        age_nxt = right_age + 1'b1;
      end
    end else if (prev_low) begin
      val_nxt = ctl.new_val;
      age_nxt = '0;
    end else if (prev_before_del) begin
      val_nxt = left_val;
      age_nxt = left_age + 1'b1;
    end else begin
      age_nxt = age_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      val_r <= FILL;
      age_r <= init_age;
    end else if (ctl.push) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

endmodule

>>> rtl/cmdec_chain.sv
// Row of cells that keeps the window sorted, with the middle element tapped.
module cmdec_chain
  import cmdec_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  output logic [PIX_W-1:0] median
);

  logic [PIX_W-1:0] val   [WINDOW];
  logic [AGE_W-1:0] age   [WINDOW];
  logic             gt    [WINDOW];
  logic             below [WINDOW+1];

  assign below[0] = 1'b0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [PIX_W-1:0] lv;
    logic [AGE_W-1:0] la;
    logic             lg;
    logic [PIX_W-1:0] rv;
    logic [AGE_W-1:0] ra;
    logic             rg;

    if (i == 0) begin : g_first
      assign lv = FILL;
      assign la = '0;
      assign lg = 1'b0;
    end else begin : g_mid_l
      assign lv = val[i-1];
      assign la = age[i-1];
      assign lg = gt[i-1];
    end

    if (i == WINDOW - 1) begin : g_last
      assign rv = FILL;
      assign ra = '0;
      assign rg = 1'b1;
    end else begin : g_mid_r
      assign rv = val[i+1];
      assign ra = age[i+1];
      assign rg = gt[i+1];
    end

    cmdec_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .init_age  (AGE_W'(i)),
      .left_val  (lv),
      .left_age  (la),
      .left_gt   (lg),
      .right_val (rv),
      .right_age (ra),
      .right_gt  (rg),
      .below_in  (below[i]),
      .val       (val[i]),
      .age       (age[i]),
      .gt        (gt[i]),
      .below_out (below[i+1])
    );
  end

  assign median = val[HALF];

endmodule

>>> rtl/column_median_decimator.sv
// Top level: row control, decimation and output register around the sorted chain.
//
//   channel  direction  signals                        transaction when
//   in       input      in_valid, in_ready, in_data    in_valid & in_ready
//   out      output     out_valid, out_ready, out_data out_valid & out_ready
//   cfg      input      cfg_we, cfg_wdata              cfg_we
//
// One pixel is accepted per cycle while in_ready is high; the sorted chain takes
// in each accepted pixel directly. The column's last pixel starts a flush that
// pushes filler pixels while rows are still owed, followed by a chain clear.
// A result waits in a pending stage and then the output register; outside the
// flush and the clear state the input stalls only when both are full. Reset is
// synchronous and restores the chain to all-filler and row_step to 10.
module column_median_decimator
  import cmdec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [STEP_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {S_RUN, S_FLUSH, S_CLEAR} state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   row_step_r;
  logic [ROW_W-1:0]    in_cnt_r, in_cnt_nxt;
  logic [CNT_W-1:0]    out_cnt_r, out_cnt_nxt;
  logic [ROW_W-1:0]    last_row_r, last_row_nxt;
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic                pend_r, pend_nxt;
  logic                pend_med_r, pend_med_nxt;
  logic                pend_last_r, pend_last_nxt;
  logic [ROW_W-1:0]    pend_row_r, pend_row_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  cell_ctl_t           ctl;
  logic [PIX_W-1:0]    median;
  logic                out_free;
  logic                slot_ok;
  logic                acc;
  logic                end_col;
  logic                emit_now;
  logic                flush_go;
  logic                do_emit;
  logic                emit_last;
  logic                transfer;
  logic [STEP_W-1:0]   step_eff;
  logic [STEP_W-1:0]   phase_inc;
  logic [CNT_W-1:0]    n_ext;
  logic [CNT_W-1:0]    out_cnt_after;

  cmdec_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .median (median)
  );

  assign out_free = !out_valid_r || out_ready;
  assign slot_ok  = !pend_r || out_free;
  assign in_ready = (state_r == S_RUN) && slot_ok;
  assign acc      = in_valid && in_ready;
  assign transfer = pend_r && out_free;
  assign n_ext    = {1'b0, in_cnt_r};
  assign end_col  = in_data.last_in_column || (in_cnt_r == ROW_W'(MAX_ROWS - 1));
  assign emit_now = (out_cnt_r + CNT_W'(LAG)) <= n_ext;
  assign flush_go = (state_r == S_FLUSH) && slot_ok;
  assign do_emit  = (acc && emit_now) || flush_go;

  always_comb begin
    if (row_step_r == '0) begin
      step_eff = STEP_W'(1);
    end else if (row_step_r > STEP_MAX) begin
      step_eff = STEP_MAX;
    end else begin
      step_eff = row_step_r;
    end
  end

  assign phase_inc = {1'b0, phase_r} + 1'b1;

  always_comb begin
    if (acc) begin
      emit_last = end_col && (out_cnt_r == n_ext);
    end else begin
      emit_last = out_cnt_r == {1'b0, last_row_r};
    end
  end

  assign out_cnt_after = out_cnt_r + CNT_W'(emit_now);

  always_comb begin
    ctl.push    = acc || flush_go;
    ctl.clear   = (state_r == S_CLEAR) && slot_ok;
    ctl.new_val = acc ? in_data.depth_in : FILL;
  end

  always_comb begin
    state_nxt     = state_r;
    in_cnt_nxt    = in_cnt_r;
    out_cnt_nxt   = out_cnt_r;
    last_row_nxt  = last_row_r;
    phase_nxt     = phase_r;
    pend_nxt      = pend_r;
    pend_med_nxt  = pend_med_r;
    pend_last_nxt = pend_last_r;
    pend_row_nxt  = pend_row_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // The pending result reads the chain before the next push changes it.
    if (transfer) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.depth_out = pend_med_r ? median : FILL;
      out_data_nxt.row_out   = pend_row_r;
      out_data_nxt.last_out  = pend_last_r;
      pend_nxt               = 1'b0;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (do_emit) begin
      pend_nxt      = 1'b1;
      pend_med_nxt  = phase_r == '0;
      pend_last_nxt = emit_last;
      pend_row_nxt  = out_cnt_r[ROW_W-1:0];
      out_cnt_nxt   = out_cnt_r + 1'b1;
      if (phase_inc >= step_eff) begin
        phase_nxt = '0;
      end else begin
        phase_nxt = phase_inc[PHASE_W-1:0];
      end
    end

    unique case (state_r)
      S_RUN: begin
        if (acc) begin
          in_cnt_nxt   = in_cnt_r + 1'b1;
          last_row_nxt = in_cnt_r;
          if (end_col) begin
            state_nxt = (out_cnt_after <= n_ext) ? S_FLUSH : S_CLEAR;
          end
        end
      end
      S_FLUSH: begin
        if (flush_go && emit_last) begin
          state_nxt = S_CLEAR;
        end
      end
      S_CLEAR: begin
        if (slot_ok) begin
          state_nxt   = S_RUN;
          in_cnt_nxt  = '0;
          out_cnt_nxt = '0;
          phase_nxt   = '0;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      row_step_r  <= STEP_RESET;
      in_cnt_r    <= '0;
      out_cnt_r   <= '0;
      phase_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_cnt_r    <= in_cnt_nxt;
      out_cnt_r   <= out_cnt_nxt;
      phase_r     <= phase_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        row_step_r <= cfg_wdata;
      end
    end
    last_row_r  <= last_row_nxt;
    pend_med_r  <= pend_med_nxt;
    pend_last_r <= pend_last_nxt;
    pend_row_r  <= pend_row_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> test/tb_column_median_decimator.sv
// Self-checking testbench for column_median_decimator: random traffic against a built-in predictor.
module tb_column_median_decimator;
  import cmdec_pkg::*;

  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_PIXELS = 170;
  localparam int MAX_PRINTS    = 40;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_we;
  logic [STEP_W-1:0] cfg_wdata;

  column_median_decimator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: one column in flight plus the step register.
  logic [PIX_W-1:0]  col_window [WINDOW];
  int unsigned       next_in_row;
  int unsigned       next_out_row;
  int unsigned       step_phase;
  logic [STEP_W-1:0] step_setting = STEP_RESET;

  in_item_t  pixel_queue [$];
  out_item_t expected_rows [$];
  int        pixels_queued   = 0;
  int        pixels_accepted = 0;
  int        rows_checked    = 0;
  int        columns_done    = 0;
  int        step_writes     = 0;
  int        error_count     = 0;
  int        idle_cycles     = 0;
  int        in_gap          = 0;
  int        out_stall       = 0;
  bit        steady_in       = 1'b0;
  bit        steady_out      = 1'b0;

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic void clear_column();
    for (int k = 0; k < WINDOW; k++) col_window[k] = FILL;
    next_in_row  = 0;
    next_out_row = 0;
    step_phase   = 0;
  endfunction

  function automatic void shift_in(logic [PIX_W-1:0] v);
    for (int k = 0; k < WINDOW - 1; k++) col_window[k] = col_window[k+1];
    col_window[WINDOW-1] = v;
  endfunction

  // Element at index HALF of the sorted window, found by rank counting.
  function automatic logic [PIX_W-1:0] column_median();
    int lt;
    int le;
    for (int k = 0; k < WINDOW; k++) begin
      lt = 0;
      le = 0;
      for (int m = 0; m < WINDOW; m++) begin
        if (col_window[m] < col_window[k]) lt++;
        if (col_window[m] <= col_window[k]) le++;
      end
      if (lt <= HALF && le > HALF) return col_window[k];
    end
    return FILL;
  endfunction

  function automatic int unsigned active_step();
    if (step_setting == '0) return 1;
    if (step_setting > STEP_MAX) return STEP_MAX;
    return step_setting;
  endfunction

  function automatic void emit_row(bit last);
    out_item_t r;
    r.depth_out = (step_phase == 0) ? column_median() : FILL;
    r.row_out   = next_out_row[ROW_W-1:0];
    r.last_out  = last;
    expected_rows.push_back(r);
    step_phase++;
    if (step_phase >= active_step()) step_phase = 0;
    next_out_row++;
  endfunction

  function automatic void predict_pixel(in_item_t px);
    int unsigned n;
    bit          ends;
    n    = next_in_row;
    ends = px.last_in_column || (n >= MAX_ROWS - 1);
    shift_in(px.depth_in);
    if (next_out_row + LAG <= n) emit_row(ends && next_out_row == n);
    next_in_row = n + 1;
    if (ends) begin
      while (next_out_row <= n) begin
        shift_in(FILL);
        emit_row(next_out_row == n);
      end
      clear_column();
      columns_done++;
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [PIX_W-1:0] pick_depth(int flavor);
    int r;
    r = $urandom_range(0, 9);
    case (flavor)
      0: begin
        return PIX_W'($urandom_range(0, 65535));
      end
      1: begin
        // Narrow band so the window holds many equal values.
        return PIX_W'($urandom_range(1000, 1012));
      end
      default: begin
        if (r < 3) return '0;
        if (r < 6) return FILL;
        return PIX_W'($urandom_range(0, 65535));
      end
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return STEP_W'($urandom_range(65, 127));
    if (r == 2) return STEP_MAX;
    if (r == 3) return STEP_W'(1);
    return STEP_W'($urandom_range(2, 63));
  endfunction

  task automatic queue_pixel(logic [PIX_W-1:0] d, bit last);
    in_item_t px;
    px.depth_in       = d;
    px.last_in_column = last;
    pixel_queue.push_back(px);
    pixels_queued++;
  endtask

  task automatic queue_pixels(int count, bit ends, int flavor);
    for (int k = 0; k < count; k++) queue_pixel(pick_depth(flavor), ends && k == count - 1);
  endtask

  task automatic wait_idle();
    while (pixels_accepted != pixels_queued) @(posedge clk);
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(logic [STEP_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    step_setting = v;
    step_writes++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_rows.size() == 0) begin
      flag_error($sformatf("unexpected result for row %0d", got.row_out));
      return;
    end
    want = expected_rows.pop_front();
    if (got.depth_out !== want.depth_out)
      flag_error($sformatf("row %0d depth_out %0d, expected %0d",
                           want.row_out, got.depth_out, want.depth_out));
    if (got.row_out !== want.row_out)
      flag_error($sformatf("row_out %0d, expected %0d", got.row_out, want.row_out));
    if (got.last_out !== want.last_out)
      flag_error($sformatf("row %0d last_out %0b, expected %0b",
                           want.row_out, got.last_out, want.last_out));
    rows_checked++;
  endtask

  // Driver: the predictor runs on every accepted transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_pixel(in_data);
        pixels_accepted++;
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        in_data  <= pixel_queue.pop_front();
        in_valid <= 1'b1;
        in_gap   = (steady_in || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor with random backpressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!steady_out && $urandom_range(0, 3) == 0) out_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Timeout: no transaction for %0d cycles.", IDLE_LIMIT);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [STEP_W-1:0] sweep [4];
    int random_pixels;
    int col_len;
    int split_at;
    int flavor;
    int r;

    sweep = '{STEP_W'(0), STEP_W'(127), STEP_MAX, STEP_W'(1)};
    random_pixels = 0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    clear_column();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: single-pixel column, a short column, and one just past the lag.
    queue_pixel('0, 1'b1);
    queue_pixel(FILL, 1'b0);
    queue_pixel('0, 1'b0);
    queue_pixel(16'h0001, 1'b1);
    for (int k = 0; k < 18; k++) queue_pixel((k % 2) ? FILL : PIX_W'(k), k == 17);
    wait_idle();

    // Every extreme of the step register, each followed by a column.
    foreach (sweep[i]) begin
      write_step(sweep[i]);
      col_len = $urandom_range(20, 45);
      queue_pixels(col_len, 1'b1, i % 3);
      random_pixels += col_len;
      wait_idle();
    end

    // Step shrinks below the current phase in the middle of a column.
    write_step(STEP_W'(9));
    queue_pixels(38, 1'b0, 0);
    wait_idle();
    write_step(STEP_W'(2));
    queue_pixels(12, 1'b1, 0);
    wait_idle();

    while (random_pixels < RANDOM_PIXELS) begin
      steady_in  = ($urandom_range(0, 4) == 0);
      steady_out = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 10) col_len = $urandom_range(1, 16);
      else if (r < 75) col_len = $urandom_range(17, 48);
      else col_len = $urandom_range(49, 90);
      flavor = $urandom_range(0, 2);
      if (col_len > 1 && $urandom_range(0, 4) == 0) begin
        split_at = $urandom_range(1, col_len - 1);
        queue_pixels(split_at, 1'b0, flavor);
        wait_idle();
        write_step(pick_step());
        queue_pixels(col_len - split_at, 1'b1, flavor);
      end else begin
        queue_pixels(col_len, 1'b1, flavor);
      end
      random_pixels += col_len;
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        write_step(pick_step());
      end
    end
    wait_idle();
    repeat (16) @(posedge clk);

    if (expected_rows.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", expected_rows.size()));
    $display("Sent %0d pixels in %0d columns; %0d result rows checked.",
             pixels_accepted, columns_done, rows_checked);
    $display("Row step written %0d times, including 0, 1, 64 and 127.", step_writes);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cmdec_pkg.sv
rtl/cmdec_cell.sv
rtl/cmdec_chain.sv
rtl/column_median_decimator.sv
test/tb_column_median_decimator.sv
